/* design/tlfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tlfr_pkg;

   // frame header constants
   localparam logic [15:0] FRAME_TAG       = 16'd2;
   localparam logic [15:0] MAX_LENGTH_INIT = 16'd1500;

   // result codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_BAD_TAG = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG = 2'd2;

   // register map
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam logic CSR_IDX_MAX_LENGTH = 1'b0;

   typedef enum logic [2:0] {
      PHASE_TAG_LO  = 3'd0,
      PHASE_TAG_HI  = 3'd1,
      PHASE_LEN_LO  = 3'd2,
      PHASE_LEN_HI  = 3'd3,
      PHASE_PAYLOAD = 3'd4
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       overrun;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       frame_last;
      logic [1:0] error_code;
      logic [7:0] overrun_total;
   } rsp_payload_type;

   // one byte handed from the input register to the parser
   typedef struct packed {
      logic       advance;
      logic [7:0] rx_byte;
      logic       overrun;
   } step_type;

   // what the parser makes of that byte
   typedef struct packed {
      logic            produce;
      rsp_payload_type payload;
   } result_type;

endpackage

`default_nettype wire

/* design/tlfr_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface tlfr_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/tlfr_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module tlfr_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [15:0]         max_frame_length,
   input  wire tlfr_pkg::step_type   step,
   output tlfr_pkg::result_type     result
);
   import tlfr_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_low_ff, held_low_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [7:0] overrun_count_ff, overrun_count_in;
   logic [15:0] word;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_TAG_LO;
         held_low_ff      <= 8'd0;
         remaining_ff     <= 16'd0;
         overrun_count_ff <= 8'd0;
      end else begin
         phase_ff         <= phase_in;
         held_low_ff      <= held_low_in;
         remaining_ff     <= remaining_in;
         overrun_count_ff <= overrun_count_in;
      end
   end

   assign word = {step.rx_byte, held_low_ff};

   // next phase and result for the byte in hand
   always_comb begin
      phase_in         = phase_ff;
      held_low_in      = held_low_ff;
      remaining_in     = remaining_ff;
      overrun_count_in = overrun_count_ff;
      result.produce               = 1'b0;
      result.payload.payload_byte  = 8'd0;
      result.payload.frame_last    = 1'b0;
      result.payload.error_code    = ERR_NONE;
      result.payload.overrun_total = overrun_count_ff;

      if (step.advance) begin
         if (step.overrun) begin
            overrun_count_in = overrun_count_ff + 8'd1;
         end else begin
            unique case (phase_ff)
               PHASE_TAG_HI: begin
                  if (word != FRAME_TAG) begin
                     phase_in = PHASE_TAG_LO;
                     result.produce            = 1'b1;
                     result.payload.error_code = ERR_BAD_TAG;
                  end else begin
                     phase_in = PHASE_LEN_LO;
                  end
               end
               PHASE_LEN_LO: begin
                  held_low_in = step.rx_byte;
                  phase_in    = PHASE_LEN_HI;
               end
               PHASE_LEN_HI: begin
                  if (word > max_frame_length) begin
                     phase_in = PHASE_TAG_LO;
                     result.produce            = 1'b1;
                     result.payload.error_code = ERR_TOO_LONG;
                  end else if (word == 16'd0) begin
                     phase_in = PHASE_TAG_LO;
                  end else begin
                     remaining_in = word;
                     phase_in     = PHASE_PAYLOAD;
                  end
               end
               PHASE_PAYLOAD: begin
                  remaining_in = remaining_ff - 16'd1;
                  result.produce              = 1'b1;
                  result.payload.payload_byte = step.rx_byte;
                  if (remaining_ff == 16'd1) begin
                     phase_in = PHASE_TAG_LO;
                     result.payload.frame_last = 1'b1;
                  end
               end
               default: begin
                  held_low_in = step.rx_byte;
                  phase_in    = PHASE_TAG_HI;
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

/* design/tag_length_frame_receiver.sv */
`timescale 1ns / 1ps
`default_nettype none

// Type-length-value deframer for a received serial byte stream.
// The req_chan sink takes one item per byte: rx_byte and an overrun flag.
// Overrun bytes are dropped and counted; others are parsed as a 2-byte
// little-endian tag (must be 2), a 2-byte little-endian length, then that
// many payload bytes. Each payload byte leaves on rsp_chan, the last one
// with frame_last set; a bad tag or a length above max_frame_length gives
// one error item and the parser hunts for a new tag.
// max_frame_length is written over the APB port at byte address 0.
// An accepted item sits in the input register; its result is formed from it
// combinationally and registered in the result register, raising rsp valid.
// Throughput: one item per cycle while rsp ready holds, set by the single
// input register feeding the parser and the single result register.
// Reset clears the parser to tag hunting, the overrun count to zero and
// max_frame_length to 1500. A stalled receiver holds the result register;
// one further item waits in the input register, then req ready drops.
module tag_length_frame_receiver (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   tlfr_stream_if.sink                                 req_chan,
   tlfr_stream_if.source                               rsp_chan,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [tlfr_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  wire logic [31:0]                            pwdata,
   output logic [31:0]                                 prdata,
   output logic                                        pready
);
   import tlfr_pkg::*;

   logic [15:0]     max_length_ff;
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   logic            advance;
   logic            csr_write;
   step_type        step;
   result_type      result;

   // configuration register
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_INIT;
      end else if (csr_write && paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_MAX_LENGTH) begin
         max_length_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_MAX_LENGTH) begin
         prdata = {16'd0, max_length_ff};
      end
   end

   // the held item moves on when the result register is free or draining
   assign advance        = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_valid_ff | advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff <= req_chan.payload;
      end
   end

   assign step.advance = advance;
   assign step.rx_byte = in_data_ff.rx_byte;
   assign step.overrun = in_data_ff.overrun;

   tlfr_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .max_frame_length (max_length_ff),
      .step             (step),
      .result           (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= result.produce;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.produce) begin
         out_data_ff <= result.payload;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

endmodule

`default_nettype wire

/* tb/tag_length_frame_receiver_tb.sv */
`timescale 1ns / 1ps

module tag_length_frame_receiver_tb;
   import tlfr_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES = 10;
   localparam int LIMIT_ITEMS = 120;
   localparam logic [15:0] HOLD_FRAME_LENGTH = 16'd32;
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_MAX_LENGTH = {CSR_IDX_MAX_LENGTH, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] ADDR_UNMAPPED = 3'd4;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   tlfr_stream_if #(.payload_type(req_payload_type)) req_if ();
   tlfr_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   tag_length_frame_receiver i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // parser mirror, kept in step with accepted items
   phase_type frame_phase = PHASE_TAG_LO;
   logic [7:0] held_byte = 8'd0;
   logic [15:0] payload_left = 16'd0;
   logic [7:0] overrun_count = 8'd0;
   logic [15:0] max_length = MAX_LENGTH_INIT;

   rsp_payload_type pending_results[$];
   rsp_payload_type oldest_result;
   int error_count = 0;
   int items_sent = 0;
   int stall_cycles = 0;
   bit sender_idle_on = 1'b1;
   bit receiver_idle_on = 1'b1;
   bit hold_off_request = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic rsp_payload_type frame_result(input logic [7:0] data, input logic last,
                                                    input logic [1:0] code);
      rsp_payload_type r;
      r.payload_byte = data;
      r.frame_last = last;
      r.error_code = code;
      r.overrun_total = overrun_count;
      return r;
   endfunction

   // advance the parser mirror by one received byte
   task automatic parse_rx_byte(input req_payload_type item);
      logic [15:0] word;
      word = {item.rx_byte, held_byte};
      if (item.overrun) begin
         overrun_count = overrun_count + 8'd1;
         return;
      end
      case (frame_phase)
         PHASE_TAG_HI: begin
            if (word != FRAME_TAG) begin
               frame_phase = PHASE_TAG_LO;
               pending_results.push_back(frame_result(8'd0, 1'b0, ERR_BAD_TAG));
            end else begin
               frame_phase = PHASE_LEN_LO;
            end
         end
         PHASE_LEN_LO: begin
            held_byte = item.rx_byte;
            frame_phase = PHASE_LEN_HI;
         end
         PHASE_LEN_HI: begin
            if (word > max_length) begin
               frame_phase = PHASE_TAG_LO;
               pending_results.push_back(frame_result(8'd0, 1'b0, ERR_TOO_LONG));
            end else if (word == 16'd0) begin
               frame_phase = PHASE_TAG_LO;
            end else begin
               payload_left = word;
               frame_phase = PHASE_PAYLOAD;
            end
         end
         PHASE_PAYLOAD: begin
            payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0) begin
               frame_phase = PHASE_TAG_LO;
               pending_results.push_back(frame_result(item.rx_byte, 1'b1, ERR_NONE));
            end else begin
               pending_results.push_back(frame_result(item.rx_byte, 1'b0, ERR_NONE));
            end
         end
         default: begin
            held_byte = item.rx_byte;
            frame_phase = PHASE_TAG_HI;
         end
      endcase
   endtask

   // input monitor
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         parse_rx_byte(req_if.payload);
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: payload_byte %0h error_code %0d",
                   rsp_if.payload.payload_byte, rsp_if.payload.error_code);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_if.payload.payload_byte !== oldest_result.payload_byte) begin
               $error("payload_byte: expected %0h, got %0h",
                      oldest_result.payload_byte, rsp_if.payload.payload_byte);
               error_count++;
            end
            if (rsp_if.payload.frame_last !== oldest_result.frame_last) begin
               $error("frame_last: expected %0b, got %0b",
                      oldest_result.frame_last, rsp_if.payload.frame_last);
               error_count++;
            end
            if (rsp_if.payload.error_code !== oldest_result.error_code) begin
               $error("error_code: expected %0d, got %0d",
                      oldest_result.error_code, rsp_if.payload.error_code);
               error_count++;
            end
            if (rsp_if.payload.overrun_total !== oldest_result.overrun_total) begin
               $error("overrun_total: expected %0d, got %0d",
                      oldest_result.overrun_total, rsp_if.payload.overrun_total);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tag_length_frame_receiver_tb: errors");
         $finish;
      end
   end

   // result receiver: random back-pressure and the long hold-off
   always begin
      @(negedge clock);
      if (hold_off_request) begin
         rsp_if.ready <= 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_off_request = 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
         rsp_if.ready <= 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // one item on the input channel; called and returns at a falling edge
   task automatic send_byte(input logic [7:0] data, input logic overrun);
      if (sender_idle_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= '{rx_byte: data, overrun: overrun};
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      @(negedge clock);
   endtask

   // a frame byte, now and then preceded by a dropped overrun byte
   task automatic send_frame_byte(input logic [7:0] data);
      if ($urandom_range(0, 11) == 0) begin
         send_byte(8'($urandom()), 1'b1);
      end
      send_byte(data, 1'b0);
   endtask

   task automatic send_word(input logic [15:0] word);
      send_frame_byte(word[7:0]);
      send_frame_byte(word[15:8]);
   endtask

   // stop offering items until every result is back and the parser is quiet
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_MAX_LENGTH) begin
         max_length = data[15:0];
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [CSR_ADDR_WIDTH-1:0] addr, input logic [15:0] want);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[15:0] !== want) begin
         $error("max_frame_length: expected %0d, got %0d", want, prdata[15:0]);
         error_count++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // length mix: oversized, zero, the limit itself when it is at most 48, mostly short
   function automatic logic [15:0] pick_length();
      int cap;
      cap = (max_length < 16'd24) ? int'(max_length) : 24;
      case ($urandom_range(0, 9))
         0: return (max_length == 16'hFFFF) ? 16'd0
                   : 16'($urandom_range(int'(max_length) + 1, 65535));
         1: return 16'd0;
         2: return (max_length <= 16'd48) ? max_length : 16'($urandom_range(1, 48));
         default: return (cap == 0) ? 16'd0 : 16'($urandom_range(1, cap));
      endcase
   endfunction

   // mostly well-formed frames, some bad tags and stray bytes
   task automatic send_random_frame();
      logic [15:0] tag;
      logic [15:0] length;
      int kind;
      kind = $urandom_range(0, 19);
      if (kind == 0 && max_length < 16'h1000) begin
         send_frame_byte(8'($urandom()));
         return;
      end
      tag = FRAME_TAG;
      if (kind == 1) begin
         tag = 16'($urandom());
         if (tag == FRAME_TAG) tag = ~tag;
      end
      send_word(tag);
      if (tag != FRAME_TAG) return;
      length = pick_length();
      send_word(length);
      if (length > max_length) return;
      repeat (length) send_frame_byte(8'($urandom()));
   endtask

   task automatic run_random_frames(input int item_count);
      int start;
      start = items_sent;
      while (items_sent - start < item_count) send_random_frame();
   endtask

   // register reads back its reset value
   task automatic test_reset_value();
      csr_read_check(ADDR_MAX_LENGTH, MAX_LENGTH_INIT);
   endtask

   // byte extremes, every result code and the corner cases of the parser
   task automatic test_directed();
      // dropped bytes before any frame
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b1);
      // two-byte frame with an overrun byte inside the payload
      send_byte(8'h02, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hAA, 1'b1);
      send_byte(8'hFF, 1'b0);
      // zero length gives nothing
      send_byte(8'h02, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      // tag in the wrong byte order
      send_byte(8'h00, 1'b0);
      send_byte(8'h02, 1'b0);
      // length one above the reset limit
      send_byte(8'h02, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hDD, 1'b0);
      send_byte(8'h05, 1'b0);
      // all-ones tag
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      // single-byte frame
      send_byte(8'h02, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h5A, 1'b0);
   endtask

   // a frame sent while the receiver stalls for a long stretch
   task automatic test_receiver_hold_off();
      hold_off_request = 1'b1;
      send_word(FRAME_TAG);
      send_word(HOLD_FRAME_LENGTH);
      repeat (HOLD_FRAME_LENGTH) send_frame_byte(8'($urandom()));
      wait_drained();
   endtask

   // overrun count wraps past 255 in the middle of a frame
   task automatic test_overrun_wrap();
      send_word(FRAME_TAG);
      send_word(16'd3);
      send_byte(8'h11, 1'b0);
      repeat (260) send_byte(8'($urandom()), 1'b1);
      send_byte(8'h22, 1'b0);
      send_byte(8'h33, 1'b0);
      wait_drained();
   endtask

   // random frames under several limits, extremes among them
   task automatic test_length_limits();
      logic [15:0] settings[5];
      settings = '{16'd0, 16'd1, 16'd37, 16'hFFFF, 16'd300};
      foreach (settings[i]) begin
         wait_drained();
         csr_write(ADDR_MAX_LENGTH, {16'($urandom()), settings[i]});
         if (i == 2) begin
            // unmapped address must leave the limit alone
            csr_write(ADDR_UNMAPPED, $urandom());
         end
         run_random_frames(LIMIT_ITEMS);
      end
      wait_drained();
   endtask

   // back-to-back traffic with no idling on either side
   task automatic test_full_rate();
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      run_random_frames(150);
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_value();
      test_directed();
      test_receiver_hold_off();
      test_overrun_wrap();
      test_length_limits();
      test_full_rate();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tag_length_frame_receiver_tb: clean");
      end else begin
         $display("tag_length_frame_receiver_tb: errors");
      end
      $finish;
   end

endmodule
